FILE: rtl/b64e_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64e_pkg;

    // Default depth of the group queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_DIGIT = 8'h30;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // One zero-filled group of up to three bytes, ready for character output.
    typedef struct packed {
        logic [7:0] g0;
        logic [7:0] g1;
        logic [7:0] g2;
        logic [1:0] n;      // Bytes in the group; characters 0..n are alphabet.
        logic       fin;    // The group closes the message.
    } group_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] alpha_char(input logic [5:0] idx);
        logic [7:0] wide;
        logic [7:0] ch;
        wide = {2'b00, idx};
        if (idx < 6'd26)
        begin
            ch = 8'(CHAR_UPPER + wide);
        end
        else if (idx < 6'd52)
        begin
            ch = 8'(CHAR_LOWER + wide - 8'd26);
        end
        else if (idx < 6'd62)
        begin
            ch = 8'(CHAR_DIGIT + wide - 8'd52);
        end
        else if (idx == 6'd62)
        begin
            ch = CHAR_PLUS;
        end
        else
        begin
            ch = CHAR_SLASH;
        end
        return ch;
    endfunction

endpackage

FILE: rtl/b64e_front.sv
// Front part: accepts bytes, gathers them into groups of up to three and pushes them into the queue.
module b64e_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               final_byte,
    input  b64e_pkg::q_status_t q_status,
    output logic               push,
    output b64e_pkg::group_t   push_group
);
    import b64e_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [7:0] p0_reg;
    logic [7:0] p1_reg;
    logic       accept;

    // Stall while the queue has no room, so a closing byte always finds a slot.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (count_reg == 2'd2 || final_byte);

    always_comb
    begin
        push_group.g0  = (count_reg == 2'd0) ? data_byte : p0_reg;
        push_group.g1  = (count_reg == 2'd0) ? 8'd0 :
                         (count_reg == 2'd1) ? data_byte : p1_reg;
        push_group.g2  = (count_reg == 2'd2) ? data_byte : 8'd0;
        push_group.n   = 2'(count_reg + 2'd1);
        push_group.fin = final_byte;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = push ? 2'd0 : 2'(count_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Pending bytes carry no reset; each is written before it is read.
    always_ff @(posedge clk)
    begin
        if (accept && !push)
        begin
            case (count_reg)
                2'd0:    p0_reg <= data_byte;
                default: p1_reg <= data_byte;
            endcase
        end
    end

endmodule

FILE: rtl/b64e_queue.sv
// Short group queue that decouples the front from the back.
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64e_pkg::group_t    push_group,
    input  logic                pop,
    output b64e_pkg::group_t    head_group,
    output b64e_pkg::q_status_t q_status
);
    import b64e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    group_t           entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign head_group     = entries_reg[rd_ptr_reg];
    assign q_status.full  = (cnt_reg == FULL_CNT);
    assign q_status.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

FILE: rtl/b64e_back.sv
// Back part: turns each queued group into four characters, one per cycle while out_stall is low.
module b64e_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64e_pkg::q_status_t q_status,
    input  b64e_pkg::group_t    head_group,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_char,
    output logic                end_of_message
);
    import b64e_pkg::*;

    group_t     grp_reg;
    logic       busy_reg;
    logic [1:0] k_reg;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       eom_reg;
    logic       out_free;
    logic       advance;
    logic       last_char;
    logic [5:0] idx;
    logic [7:0] ch;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = busy_reg && out_free;
    assign last_char = (k_reg == 2'd3);
    assign pop       = (!busy_reg || (advance && last_char)) && !q_status.empty;

    always_comb
    begin
        case (k_reg)
            2'd0:    idx = grp_reg.g0[7:2];
            2'd1:    idx = {grp_reg.g0[1:0], grp_reg.g1[7:4]};
            2'd2:    idx = {grp_reg.g1[3:0], grp_reg.g2[7:6]};
            default: idx = grp_reg.g2[5:0];
        endcase
        ch = (k_reg <= grp_reg.n) ? alpha_char(idx) : CHAR_PAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                k_reg    <= 2'd0;
            end
            else if (advance)
            begin
                busy_reg <= !last_char;
                k_reg    <= 2'(k_reg + 2'd1);
            end
            if (out_free)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            grp_reg <= head_group;
        end
        if (advance)
        begin
            out_char_reg <= ch;
            eom_reg      <= grp_reg.fin && last_char;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_char       = out_char_reg;
    assign end_of_message = eom_reg;

endmodule

FILE: rtl/base64_stream_encoder.sv
// Top level of the streaming base64 encoder: front, group queue and character back end.
// A closed group goes from a queue entry via the back's group register to its output register.
// Throughput: bytes are taken one per cycle while the queue has room; the back emits one
// character per cycle while out_stall is low, so a sustained stream is paced by the back,
// whose single output register is loaded once per character.
// Reset (rst_n, asynchronous, active low) empties the queue and clears the group count.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       end_of_message
);
    import b64e_pkg::*;

    // The front gathers bytes and pushes a zero-filled group either when a
    // third byte arrives or when a byte is marked final. The queue lets the
    // front keep taking bytes while the back is still spelling out an
    // earlier group, and the back's output register lets the back move on
    // to the next group while a finished character waits to be taken.
    logic      push;
    logic      pop;
    group_t    push_group;
    group_t    head_group;
    q_status_t q_status;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_status   (q_status),
        .push       (push),
        .push_group (push_group)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head_group (head_group),
        .q_status   (q_status)
    );

    // Each group yields four characters; positions past the group's byte
    // count are padding, and the fourth one of a final group ends the message.
    b64e_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .head_group     (head_group),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_char       (out_char),
        .end_of_message (end_of_message)
    );

`ifndef SYNTH
    // A group is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_status.full)
        else $error("group pushed into a full queue");

    // A group is never popped from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty)
        else $error("group popped from an empty queue");

    // An accepted final byte always flushes its group into the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && final_byte) |-> push)
        else $error("final byte did not flush its group");
`endif

endmodule

FILE: test/base64_stream_encoder_test.sv
// Self-checking testbench for the streaming base64 encoder, with its own encoding predictor.
module base64_stream_encoder_test;

    import b64e_pkg::*;

    // The run is ended by force if it is still going after this many cycles.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Least number of random bytes to send after the directed messages.
    localparam int unsigned RANDOM_ITEMS = 185;
    // Cycles to watch for stray characters once nothing is expected any more.
    localparam int unsigned SETTLE_CYCLES = 20;

    // The standard alphabet, first symbol in the top byte.
    localparam logic [8*64-1:0] SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Directed messages, item 0 in the top byte. Bit i of DIRECTED_LAST marks item i
    // as the final byte of its message. The messages are:
    //   00 / FF             a single byte, padded with two '=' characters
    //   FF FF               two bytes, padded with one '='
    //   00 00 00            the lowest group, all 'A'
    //   FB FF BF            a group that gives the two symbols past the digits
    //   FF FF FF 00         a full group of ones, then a one-byte tail
    //   4D 61 6E 4D 61      text, with a two-byte tail
    //   10 32 .. BA         two full groups, the final byte closing the second one
    localparam int unsigned DIRECTED_ITEMS = 25;
    localparam logic [8*25-1:0] DIRECTED_BYTES = {
        8'h00,
        8'hFF,
        8'hFF, 8'hFF,
        8'h00, 8'h00, 8'h00,
        8'hFB, 8'hFF, 8'hBF,
        8'hFF, 8'hFF, 8'hFF, 8'h00,
        8'h4D, 8'h61, 8'h6E, 8'h4D, 8'h61,
        8'h10, 8'h32, 8'h54, 8'h76, 8'h98, 8'hBA
    };
    localparam logic [24:0] DIRECTED_LAST = 25'h104224B;

    // One byte waiting to be sent, with the idle cycles that go before it. When
    // wait_for_drain is set, the sender holds it back until every character
    // expected so far has come out.
    typedef struct {
        logic [7:0]  data;
        logic        last;
        int unsigned gap;
        logic        wait_for_drain;
    } byte_item_t;

    // One character that the encoder is expected to put out.
    typedef struct packed {
        logic [7:0] code;
        logic       eom;
    } enc_char_t;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte      = 8'h00;
    logic       final_byte     = 1'b0;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic [7:0] out_char;
    logic       end_of_message;

    byte_item_t  byte_queue[$];
    byte_item_t  next_item;
    enc_char_t   expected_chars[$];
    int unsigned mismatch_count = 0;
    int unsigned chars_checked  = 0;
    int unsigned cycle_count    = 0;
    int unsigned gap_count      = 0;
    int unsigned stall_left     = 0;
    int unsigned stall_next;

    // Predictor state: the bytes held for the group being gathered and how many there are.
    logic [7:0] held_bytes[2];
    int unsigned held_count = 0;

    base64_stream_encoder DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .final_byte     (final_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_char       (out_char),
        .end_of_message (end_of_message)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Takes one accepted byte into the predicted group. A byte that completes a group,
    // or that ends the message, queues four characters: symbols for the bytes present
    // plus one, then '=' up to four. The end mark rides on the fourth character of a
    // final group, whether the group is full or partial.
    task automatic encode_byte(input logic [7:0] data, input logic last);
        logic [23:0] group_bits;
        logic [5:0]  sym_index;
        enc_char_t   item;
        int unsigned filled;
        case (held_count)
            0: group_bits = {data, 16'h0000};
            1: group_bits = {held_bytes[0], data, 8'h00};
            default: group_bits = {held_bytes[0], held_bytes[1], data};
        endcase
        filled = held_count + 1;
        if (filled < 3 && !last)
        begin
            held_bytes[held_count] = data;
            held_count = filled;
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                sym_index = group_bits[18 - 6 * k +: 6];
                item.code = (k <= filled) ? SYMBOLS[8 * (63 - sym_index) +: 8] : CHAR_PAD;
                item.eom  = last && (k == 3);
                expected_chars.push_back(item);
            end
            held_count = 0;
        end
    endtask

    // Compares one accepted character with the oldest one expected.
    task automatic check_char(input logic [7:0] code, input logic eom);
        enc_char_t want;
        if (expected_chars.size() == 0)
        begin
            report_mismatch($sformatf("character %h came with none expected", code));
        end
        else
        begin
            want = expected_chars.pop_front();
            if (code !== want.code)
                report_mismatch($sformatf("character %0d: out_char %h, expected %h",
                                          chars_checked, code, want.code));
            if (eom !== want.eom)
                report_mismatch($sformatf("character %0d: end_of_message %b, expected %b",
                                          chars_checked, eom, want.eom));
        end
        chars_checked++;
    endtask

    // Queues one byte. In a calm stretch the sender puts no gap before it.
    task automatic add_byte(input logic [7:0] data, input logic last, input logic calm,
                            input logic drain);
        byte_item_t item;
        item.data           = data;
        item.last           = last;
        item.gap            = calm ? 0 : $urandom_range(0, 7);
        item.wait_for_drain = drain;
        byte_queue.push_back(item);
    endtask

    // Sender. A new item is put on the inputs once the one before it has been taken and
    // its gap has run out. While stalled, the payload stays as it is. An item marked to
    // wait for the drain is held back while a byte is still being taken or characters
    // are still due, so the encoder runs empty before it goes in.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= 8'h00;
            final_byte <= 1'b0;
            gap_count  <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (byte_queue.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (byte_queue[0].wait_for_drain && (in_valid || expected_chars.size() != 0))
            begin
                in_valid <= 1'b0;
            end
            else if (gap_count < byte_queue[0].gap)
            begin
                in_valid  <= 1'b0;
                gap_count <= gap_count + 1;
            end
            else
            begin
                next_item = byte_queue.pop_front();
                next_item.wait_for_drain = 1'b0;
                in_valid   <= 1'b1;
                data_byte  <= next_item.data;
                final_byte <= next_item.last;
                gap_count  <= 0;
            end
        end
    end

    // Monitor and receiver. Each accepted byte goes through the predictor and each
    // accepted character is checked. The predictor runs first, though the encoder's
    // latency keeps a byte's characters from showing up on the edge that takes it.
    // After each character the receiver may draw a stall at random; now and then
    // it also stalls while nothing is offered, so stalls land on the first character
    // of a group too. Every third stretch of 48 characters runs with no stalls at all.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                encode_byte(data_byte, final_byte);
            stall_next = stall_left;
            if (out_valid && !out_stall)
            begin
                check_char(out_char, end_of_message);
                stall_next = ((chars_checked / 48) % 3 == 2) ? 0 : $urandom_range(0, 7);
            end
            else if (stall_next != 0)
            begin
                stall_next = stall_next - 1;
            end
            else if (!out_valid && (chars_checked / 48) % 3 != 2 && $urandom_range(0, 15) == 0)
            begin
                stall_next = $urandom_range(1, 7);
            end
            stall_left <= stall_next;
            out_stall  <= (stall_next != 0);
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("base64_stream_encoder_test: FAIL");
            $finish;
        end
    end

    // Fills the send queue, releases reset, and waits for the encoder to run dry.
    initial
    begin
        int unsigned random_sent;
        int unsigned msg_len;
        int unsigned msg_index;
        logic        calm;

        // Directed messages, with random gaps.
        for (int i = 0; i < DIRECTED_ITEMS; i++)
            add_byte(DIRECTED_BYTES[8 * (DIRECTED_ITEMS - 1 - i) +: 8], DIRECTED_LAST[i],
                     1'b0, 1'b0);

        // Random messages, most of them short, now and then a long one. Every message
        // ends with a final byte, so all tail lengths come up. Every fourth message is
        // sent without gaps, and every twelfth, the first among them, waits for the
        // encoder to drain before it starts.
        random_sent = 0;
        msg_index   = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                                  : $urandom_range(1, 9);
            calm = (msg_index % 4 == 3);
            for (int i = 0; i < msg_len; i++)
                add_byte(8'($urandom_range(0, 255)), i == msg_len - 1, calm,
                         (msg_index % 12 == 0) && (i == 0));
            random_sent += msg_len;
            msg_index++;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("base64_stream_encoder_test: PASS");
        else
            $display("base64_stream_encoder_test: FAIL");
        $finish;
    end

endmodule
